// ----- sv/hrst_pkg.sv -----
// shared types, codes and helpers for the hamming radius search table
`timescale 1ns / 1ps

package hrst_pkg;

    // fixed field widths of the channels
    localparam int OPCODE_W = 2;
    localparam int CODE_W   = 64;
    localparam int ID_W     = 32;
    localparam int RADIUS_W = 7;
    localparam int STATUS_W = 3;
    localparam int TALLY_W  = 6;
    localparam int DIST_W   = 7;

    // request opcodes
    localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd2;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MATCH   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic start;    // latch request, clear scan counters, do an add
        logic issue;    // read the entry at the scan index
        logic consume;  // act on the entry read last
        logic finish;   // load the closing response
    } hrst_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_end;  // every held entry has been read
        logic rd_valid;  // read data waits to be acted on
        logic rd_emit;   // that entry gives a match response
        logic out_free;  // response register can take a new one
    } hrst_sts_t;

    function automatic logic [DIST_W-1:0] popcount64(input logic [CODE_W-1:0] v);
        logic [DIST_W-1:0] acc;
        acc = '0;
        for (int b = 0; b < CODE_W; b++)
        begin
            acc = acc + DIST_W'(v[b]);
        end
        return acc;
    endfunction

endpackage

// ----- sv/hrst_if.sv -----
// request and response channel interfaces
`timescale 1ns / 1ps

interface hrst_req_if import hrst_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [CODE_W-1:0]   code;
    logic [ID_W-1:0]     entry_id;
    logic [RADIUS_W-1:0] radius;

    modport source (output valid, opcode, code, entry_id, radius, input ready);
    modport sink   (input valid, opcode, code, entry_id, radius, output ready);
endinterface

interface hrst_rsp_if import hrst_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     match_id;
    logic [CODE_W-1:0]   match_code;
    logic [TALLY_W-1:0]  tally;
    logic                last;

    modport source (output valid, status, match_id, match_code, tally, last, input ready);
    modport sink   (input valid, status, match_id, match_code, tally, last, output ready);
endinterface

// ----- sv/hrst_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module hrst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/hrst_ctrl.sv -----
// sequencing state machine of the search table
`timescale 1ns / 1ps

module hrst_ctrl import hrst_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [OPCODE_W-1:0] req_opcode,
    output logic                req_ready,
    input  hrst_sts_t           sts,
    output hrst_cmd_t           cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        req_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    case (req_opcode) inside
                        OP_ADD:
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_DONE;
                        end
                        OP_DELETE, OP_SEARCH:
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.consume = sts.rd_valid && (!sts.rd_emit || sts.out_free);
                cmd.issue   = !sts.scan_end && (!sts.rd_valid || cmd.consume);
                if (sts.scan_end && !sts.rd_valid)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/hrst_dp.sv -----
// entry store, scan counters, distance check and response register
`timescale 1ns / 1ps

module hrst_dp import hrst_pkg::*; #(
    parameter int CAPACITY  = 32,
    parameter int CODE_BITS = 64,
    parameter int ID_BITS   = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hrst_cmd_t           cmd,
    output hrst_sts_t           sts,
    input  logic [OPCODE_W-1:0] req_opcode,
    input  logic [CODE_W-1:0]   req_code,
    input  logic [ID_W-1:0]     req_entry_id,
    input  logic [RADIUS_W-1:0] req_radius,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [STATUS_W-1:0] rsp_status,
    output logic [ID_W-1:0]     rsp_match_id,
    output logic [CODE_W-1:0]   rsp_match_code,
    output logic [TALLY_W-1:0]  rsp_tally,
    output logic                rsp_last
);

    localparam int CodeW = CODE_BITS;
    localparam int IdW   = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int EntW  = CodeW + IdW;
    localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CntW  = $clog2(CAPACITY + 1);

    // request latched for the scan
    logic [OPCODE_W-1:0] op_reg, op_next;
    logic [CodeW-1:0]    code_reg, code_next;
    logic [IdW-1:0]      id_reg, id_next;
    logic [RADIUS_W-1:0] radius_reg, radius_next;

    logic [CntW-1:0] fill_reg, fill_next;
    logic [CntW-1:0] idx_reg, idx_next;
    logic [CntW-1:0] kept_reg, kept_next;
    logic [CntW-1:0] found_reg, found_next;
    logic            rdv_reg, rdv_next;
    logic            full_reg, full_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ID_W-1:0]     out_id_reg, out_id_next;
    logic [CODE_W-1:0]   out_code_reg, out_code_next;
    logic [TALLY_W-1:0]  out_tally_reg, out_tally_next;
    logic                out_last_reg, out_last_next;

    logic             we;
    logic [AddrW-1:0] waddr;
    logic [EntW-1:0]  wdata;
    logic [EntW-1:0]  rdata;
    logic [CodeW-1:0] rd_code;
    logic [IdW-1:0]   rd_id;
    logic             hit;
    logic [DIST_W-1:0] ham_dist;
    logic             out_free;
    logic             has_room;

    hrst_ram #(
        .WIDTH (EntW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.issue),
        .raddr (idx_reg[AddrW-1:0]),
        .rdata (rdata)
    );

    assign rd_code  = rdata[CodeW-1:0];
    assign rd_id    = rdata[EntW-1:CodeW];
    assign hit      = (rd_id == id_reg) && (rd_code == code_reg);
    assign ham_dist = popcount64(CODE_W'(rd_code ^ code_reg));
    assign out_free = !out_valid_reg || rsp_ready;
    assign has_room = fill_reg < CntW'(CAPACITY);

    assign sts.scan_end = (idx_reg == fill_reg);
    assign sts.rd_valid = rdv_reg;
    assign sts.rd_emit  = rdv_reg && (op_reg == OP_SEARCH)
                          && ({1'b0, ham_dist} <= {1'b0, radius_reg});
    assign sts.out_free = out_free;

    // store write: an add appends, a delete moves kept entries down
    always_comb
    begin
        we    = 1'b0;
        waddr = fill_reg[AddrW-1:0];
        wdata = {req_entry_id[IdW-1:0], req_code[CodeW-1:0]};
        if (cmd.start && (req_opcode == OP_ADD) && has_room)
        begin
            we = 1'b1;
        end
        else if (cmd.consume && (op_reg == OP_DELETE) && !hit)
        begin
            we    = 1'b1;
            waddr = kept_reg[AddrW-1:0];
            wdata = rdata;
        end
    end

    always_comb
    begin
        op_next     = op_reg;
        code_next   = code_reg;
        id_next     = id_reg;
        radius_next = radius_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        kept_next   = kept_reg;
        found_next  = found_reg;
        full_next   = full_reg;
        rdv_next    = rdv_reg;

        out_valid_next  = out_valid_reg && !rsp_ready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_code_next   = out_code_reg;
        out_tally_next  = out_tally_reg;
        out_last_next   = out_last_reg;

        if (cmd.start)
        begin
            op_next     = req_opcode;
            code_next   = req_code[CodeW-1:0];
            id_next     = req_entry_id[IdW-1:0];
            radius_next = req_radius;
            idx_next    = '0;
            kept_next   = '0;
            found_next  = '0;
            rdv_next    = 1'b0;
            full_next   = !has_room;
            if ((req_opcode == OP_ADD) && has_room)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end

        if (cmd.consume)
        begin
            rdv_next = 1'b0;
            if (op_reg == OP_DELETE)
            begin
                if (hit)
                begin
                    found_next = found_reg + 1'b1;
                end
                else
                begin
                    kept_next = kept_reg + 1'b1;
                end
            end
            else if (sts.rd_emit)
            begin
                found_next      = found_reg + 1'b1;
                out_valid_next  = 1'b1;
                out_status_next = ST_MATCH;
                out_id_next     = ID_W'(rd_id);
                out_code_next   = CODE_W'(rd_code);
                out_tally_next  = '0;
                out_last_next   = 1'b0;
            end
        end

        if (cmd.issue)
        begin
            idx_next = idx_reg + 1'b1;
            rdv_next = 1'b1;
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            out_id_next    = '0;
            out_code_next  = '0;
            out_last_next  = 1'b1;
            case (op_reg)
                OP_ADD:
                begin
                    out_status_next = full_reg ? ST_FULL : ST_ADDED;
                    out_tally_next  = TALLY_W'(fill_reg);
                end
                OP_DELETE:
                begin
                    out_status_next = ST_DELETED;
                    out_tally_next  = TALLY_W'(found_reg);
                    fill_next       = kept_reg;
                end
                default:
                begin
                    out_status_next = ST_DONE;
                    out_tally_next  = TALLY_W'(found_reg);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            idx_reg       <= '0;
            kept_reg      <= '0;
            found_reg     <= '0;
            rdv_reg       <= 1'b0;
            full_reg      <= 1'b0;
            op_reg        <= OP_ADD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            kept_reg      <= kept_next;
            found_reg     <= found_next;
            rdv_reg       <= rdv_next;
            full_reg      <= full_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg       <= code_next;
        id_reg         <= id_next;
        radius_reg     <= radius_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_code_reg   <= out_code_next;
        out_tally_reg  <= out_tally_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp_valid      = out_valid_reg;
    assign rsp_status     = out_status_reg;
    assign rsp_match_id   = out_id_reg;
    assign rsp_match_code = out_code_reg;
    assign rsp_tally      = out_tally_reg;
    assign rsp_last       = out_last_reg;

endmodule

// ----- sv/hamming_radius_search_table.sv -----
// top level of the hamming radius search table
`timescale 1ns / 1ps

// channel  dir  handshake      payload
// req      in   valid / ready  opcode, code, entry_id, radius
// rsp      out  valid / ready  status, match_id, match_code, tally, last
//
// an add: the transfer on req, then the response is loaded
// a delete or a search walks the single read port of the entry store one entry per cycle
// when no match waits for the response register; at most one match per entry
// reset (rst_n low, asynchronous) empties the table; stored entries are not cleared
// a stalled rsp holds the scan only when a match must wait for the response register
// req is taken only between operations; an unknown opcode is taken and dropped

module hamming_radius_search_table import hrst_pkg::*; #(
    parameter int CAPACITY  = 32,
    parameter int CODE_BITS = 64,
    parameter int ID_BITS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    hrst_req_if.sink    req,
    hrst_rsp_if.source  rsp
);

    // command and status between sequencer and datapath
    hrst_cmd_t cmd;
    hrst_sts_t sts;

    hrst_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_opcode (req.opcode),
        .req_ready  (req.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // entry store plus the response register, which decouples rsp stalls from req
    hrst_dp #(
        .CAPACITY  (CAPACITY),
        .CODE_BITS (CODE_BITS),
        .ID_BITS   (ID_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_opcode     (req.opcode),
        .req_code       (req.code),
        .req_entry_id   (req.entry_id),
        .req_radius     (req.radius),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .rsp_status     (rsp.status),
        .rsp_match_id   (rsp.match_id),
        .rsp_match_code (rsp.match_code),
        .rsp_tally      (rsp.tally),
        .rsp_last       (rsp.last)
    );

    // scan never reads past the held entries
    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !sts.scan_end)
        else $error("entry read beyond fill count");

    // a match is only loaded when the response register can take it
    a_match_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.consume && sts.rd_emit) |-> sts.out_free)
        else $error("match response would overwrite a pending one");

    // a new request is never taken while an operation is in flight
    a_req_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> (!cmd.issue && !cmd.consume && !cmd.finish))
        else $error("request transfer during an operation");

    // match responses are never the closing one
    a_match_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == ST_MATCH)) |-> !rsp.last)
        else $error("match response flagged as last");

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench for the hamming radius search table
`timescale 1ns / 1ps

module tb_top import hrst_pkg::*; ();

    // table depth of the block as built (default parameters)
    localparam int SLOTS = 32;
    // cycles with no transfer on either channel before the run is declared hung
    localparam int HANG_LIMIT = 2000;
    // a delete or search on a full table scans all SLOTS entries
    localparam int SETTLE_CYCLES = 60;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_ITEMS = 280;
    // opcode value with no operation behind it, dropped by the block
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     match_id;
        logic [CODE_W-1:0]   match_code;
        logic [TALLY_W-1:0]  tally;
        logic                last;
    } answer_t;

    logic clk;
    logic rst_n;

    hrst_req_if req_if ();
    hrst_rsp_if rsp_if ();

    hamming_radius_search_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // shadow copy of the entry list, kept in insertion order
    logic [CODE_W-1:0] shadow_code [SLOTS];
    logic [ID_W-1:0]   shadow_id   [SLOTS];
    int                shadow_fill;

    // responses the block still owes, oldest first
    answer_t answers_due [$];

    int mismatch_count;
    int quiet_cycles;
    int burst_left;

    // receiver stall pattern state
    int   rx_mode;
    int   rx_mode_left;
    int   rx_hold_left;
    logic rx_hold_level;

    //------------------------------------------------------------------
    // clock
    //------------------------------------------------------------------
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    //------------------------------------------------------------------
    // prediction
    //------------------------------------------------------------------
    function automatic void owe_answer(input logic [STATUS_W-1:0] status,
                                       input logic [ID_W-1:0] id,
                                       input logic [CODE_W-1:0] code,
                                       input int tally, input logic last);
        answer_t a;
        a.status     = status;
        a.match_id   = id;
        a.match_code = code;
        a.tally      = TALLY_W'(tally);
        a.last       = last;
        answers_due = {answers_due, a};
    endfunction

    // applies one accepted request to the shadow list and queues what it answers
    function automatic void apply_list_op(input logic [OPCODE_W-1:0] op,
                                          input logic [CODE_W-1:0] code,
                                          input logic [ID_W-1:0] id,
                                          input logic [RADIUS_W-1:0] radius);
        int kept;
        int hits;
        kept = 0;
        hits = 0;
        case (op)
            OP_ADD:
            begin
                if (shadow_fill < SLOTS)
                begin
                    shadow_code[shadow_fill] = code;
                    shadow_id[shadow_fill]   = id;
                    shadow_fill++;
                    owe_answer(ST_ADDED, '0, '0, shadow_fill, 1'b1);
                end
                else
                begin
                    // full list: entry dropped, count unchanged
                    owe_answer(ST_FULL, '0, '0, shadow_fill, 1'b1);
                end
            end
            OP_DELETE:
            begin
                // compact the survivors in place so order is kept
                for (int i = 0; i < shadow_fill; i++)
                begin
                    if (shadow_id[i] == id && shadow_code[i] == code)
                        continue;
                    shadow_code[kept] = shadow_code[i];
                    shadow_id[kept]   = shadow_id[i];
                    kept++;
                end
                owe_answer(ST_DELETED, '0, '0, shadow_fill - kept, 1'b1);
                shadow_fill = kept;
            end
            OP_SEARCH:
            begin
                for (int i = 0; i < shadow_fill; i++)
                begin
                    if ($countones(shadow_code[i] ^ code) <= int'(radius))
                    begin
                        owe_answer(ST_MATCH, shadow_id[i], shadow_code[i], 0, 1'b0);
                        hits++;
                    end
                end
                owe_answer(ST_DONE, '0, '0, hits, 1'b1);
            end
            default:
            begin
                // unknown opcode: no state change, no response
            end
        endcase
    endfunction

    //------------------------------------------------------------------
    // request driver: bursts of random length separated by random gaps
    //------------------------------------------------------------------
    task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [CODE_W-1:0] code,
                           input logic [ID_W-1:0] id, input logic [RADIUS_W-1:0] radius);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                req_if.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        req_if.valid    <= 1'b1;
        req_if.opcode   <= op;
        req_if.code     <= code;
        req_if.entry_id <= id;
        req_if.radius   <= radius;
        // hold until the block takes the transfer
        do
            @(posedge clk);
        while (!req_if.ready);
        apply_list_op(op, code, id, radius);
    endtask

    //------------------------------------------------------------------
    // response sink: ready follows a pattern that changes mode now and then
    //------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 120);
        end
        rx_mode_left--;
        case (rx_mode)
            0: rsp_if.ready <= 1'b1;                          // no back-pressure
            1: rsp_if.ready <= 1'($urandom_range(0, 1));      // coin flip
            2: rsp_if.ready <= ($urandom_range(0, 7) != 0);   // rare stalls
            default:
            begin
                // long alternating stretches of stall and flow
                if (rx_hold_left == 0)
                begin
                    rx_hold_left  = $urandom_range(1, 20);
                    rx_hold_level = ~rx_hold_level;
                end
                rx_hold_left--;
                rsp_if.ready <= rx_hold_level;
            end
        endcase
    end

    //------------------------------------------------------------------
    // response checker
    //------------------------------------------------------------------
    function automatic void report_mismatch(input string what, input answer_t want,
                                            input answer_t got);
        if (mismatch_count < MAX_REPORTS)
        begin
            $display("%0t mismatch (%s)", $realtime, what);
            $display("  exp status=%0d id=%h code=%h tally=%0d last=%b",
                     want.status, want.match_id, want.match_code, want.tally, want.last);
            $display("  got status=%0d id=%h code=%h tally=%0d last=%b",
                     got.status, got.match_id, got.match_code, got.tally, got.last);
        end
        mismatch_count++;
    endfunction

    always @(posedge clk)
    begin
        answer_t got;
        answer_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got.status     = rsp_if.status;
            got.match_id   = rsp_if.match_id;
            got.match_code = rsp_if.match_code;
            got.tally      = rsp_if.tally;
            got.last       = rsp_if.last;
            if (answers_due.size() == 0)
            begin
                report_mismatch("response with nothing outstanding", '0, got);
            end
            else
            begin
                want = answers_due.pop_front();
                if (got.status !== want.status || got.match_id !== want.match_id ||
                    got.match_code !== want.match_code || got.tally !== want.tally ||
                    got.last !== want.last)
                    report_mismatch("field differs", want, got);
            end
        end
    end

    //------------------------------------------------------------------
    // hang watchdog: counts cycles in which neither channel moves a transfer
    //------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // stimulus helpers
    //------------------------------------------------------------------
    function automatic logic [CODE_W-1:0] any_code();
        return {$urandom, $urandom};
    endfunction

    // mostly a code up to 8 bit flips away from a held entry, so small radii still hit
    function automatic logic [CODE_W-1:0] nearby_code();
        logic [CODE_W-1:0] c;
        case ($urandom_range(0, 9))
            0: c = '0;
            1: c = '1;
            2, 3: c = any_code();
            default:
            begin
                if (shadow_fill > 0)
                    c = shadow_code[$urandom_range(0, shadow_fill - 1)];
                else
                    c = any_code();
                repeat ($urandom_range(0, 8))
                    c[$urandom_range(0, CODE_W - 1)] ^= 1'b1;
            end
        endcase
        return c;
    endfunction

    // ids mostly from a small pool make repeated entries likely
    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return ID_W'($urandom_range(1, 6));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [RADIUS_W-1:0] pick_radius();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return RADIUS_W'(CODE_W);
            2, 3, 4, 5, 6, 7: return RADIUS_W'($urandom_range(0, 12));
            default: return RADIUS_W'($urandom_range(0, CODE_W));
        endcase
    endfunction

    //------------------------------------------------------------------
    // tests
    //------------------------------------------------------------------

    // operations on an empty list, plus an unknown opcode
    task automatic test_empty_list();
        send_op(OP_SEARCH, '0, '0, '0);
        send_op(OP_SEARCH, '1, '1, RADIUS_W'(CODE_W));
        send_op(OP_DELETE, '0, '0, '0);
        send_op(OP_UNUSED, '1, '1, '1);
    endtask

    // extreme codes and ids, duplicates, partial-key deletes, radius bounds
    task automatic test_extreme_entries();
        send_op(OP_ADD, '0, '0, '0);
        send_op(OP_ADD, '1, '1, '1);
        send_op(OP_ADD, {32{2'b01}}, ID_W'(1), '0);
        send_op(OP_ADD, {32{2'b10}}, ID_W'(1), '0);
        send_op(OP_ADD, '0, '0, '0);
        send_op(OP_SEARCH, '0, '1, '0);                      // exact hits only
        send_op(OP_SEARCH, '1, '0, RADIUS_W'(CODE_W - 1));   // all but the zero codes
        send_op(OP_SEARCH, {32{2'b01}}, '0, RADIUS_W'(CODE_W));
        send_op(OP_SEARCH, '0, '0, RADIUS_W'(CODE_W / 2));
        send_op(OP_UNUSED, '0, '0, '0);
        send_op(OP_DELETE, '0, ID_W'(1), '0);                // id differs: nothing removed
        send_op(OP_DELETE, {32{2'b01}}, ID_W'(2), '0);       // code held, id not
        send_op(OP_DELETE, '0, '0, '0);                      // both duplicates go
        send_op(OP_SEARCH, '1, '1, RADIUS_W'(CODE_W));
        send_op(OP_DELETE, '1, '1, '1);
        send_op(OP_SEARCH, '0, '0, RADIUS_W'(CODE_W));
    endtask

    // fill to capacity, overflow, full scan, then punch a hole and refill
    task automatic test_full_list();
        int pick;
        while (shadow_fill < SLOTS)
            send_op(OP_ADD, nearby_code(), pick_id(), pick_radius());
        repeat (3)
            send_op(OP_ADD, any_code(), $urandom, pick_radius());
        send_op(OP_SEARCH, any_code(), $urandom, RADIUS_W'(CODE_W));
        pick = $urandom_range(1, SLOTS - 2);
        send_op(OP_DELETE, shadow_code[pick], shadow_id[pick], '0);
        send_op(OP_SEARCH, any_code(), '0, RADIUS_W'(CODE_W));
        send_op(OP_ADD, any_code(), $urandom, '0);
        send_op(OP_ADD, any_code(), $urandom, '0);
    endtask

    // mixed traffic; unknown opcodes are sprinkled in but not counted
    task automatic test_random_mix(input int count);
        int done_items;
        int sel;
        int pick;
        done_items = 0;
        while (done_items < count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 4)
            begin
                send_op(OP_UNUSED, any_code(), $urandom, RADIUS_W'($urandom));
                continue;
            end
            if (sel < 40)
            begin
                send_op(OP_ADD, nearby_code(), pick_id(), pick_radius());
            end
            else if (sel < 62)
            begin
                pick = (shadow_fill > 0) ? $urandom_range(0, shadow_fill - 1) : 0;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6:
                    begin
                        if (shadow_fill > 0)
                            send_op(OP_DELETE, shadow_code[pick], shadow_id[pick], '0);
                        else
                            send_op(OP_DELETE, nearby_code(), pick_id(), '0);
                    end
                    7:
                    begin
                        // right code under another id must survive
                        if (shadow_fill > 0)
                            send_op(OP_DELETE, shadow_code[pick], ~shadow_id[pick], '0);
                        else
                            send_op(OP_DELETE, any_code(), $urandom, '0);
                    end
                    default: send_op(OP_DELETE, nearby_code(), pick_id(), pick_radius());
                endcase
            end
            else
            begin
                send_op(OP_SEARCH, nearby_code(), $urandom, pick_radius());
            end
            done_items++;
        end
    endtask

    // empty the list one delete at a time, each naming an entry at a random position
    task automatic test_drain();
        int pick;
        while (shadow_fill > 0)
        begin
            pick = $urandom_range(0, shadow_fill - 1);
            send_op(OP_DELETE, shadow_code[pick], shadow_id[pick], '0);
            if ($urandom_range(0, 3) == 0)
                send_op(OP_SEARCH, nearby_code(), $urandom, pick_radius());
        end
        send_op(OP_SEARCH, '0, '0, RADIUS_W'(CODE_W));
    endtask

    //------------------------------------------------------------------
    // main sequence
    //------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        req_if.valid    = 1'b0;
        req_if.opcode   = OP_ADD;
        req_if.code     = '0;
        req_if.entry_id = '0;
        req_if.radius   = '0;
        rsp_if.ready    = 1'b0;
        shadow_fill     = 0;
        mismatch_count  = 0;
        quiet_cycles    = 0;
        burst_left      = 0;
        rx_mode         = 0;
        rx_mode_left    = 0;
        rx_hold_left    = 0;
        rx_hold_level   = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_extreme_entries();
        test_full_list();
        test_random_mix(RANDOM_ITEMS);
        test_drain();

        @(negedge clk);
        req_if.valid <= 1'b0;
        // the watchdog bounds this wait if responses stop coming
        while (answers_due.size() != 0)
            @(posedge clk);
        // catch anything extra still coming out of a scan
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/hrst_pkg.sv
sv/hrst_if.sv
sv/hrst_ram.sv
sv/hrst_ctrl.sv
sv/hrst_dp.sv
sv/hamming_radius_search_table.sv
verif/tb_top.sv
